// ===== hw/rtl/smac_pkg.sv =====
// Package for the stack machine ALU core.
// Command codes, fault codes and the operand word type; no dependencies.
`default_nettype none
package smac_pkg;

    typedef logic [31:0] t_word;
    typedef logic [4:0]  t_cmd;
    typedef logic [2:0]  t_fault;

    localparam t_cmd CMD_PUSH_CONST = 5'd0;
    localparam t_cmd CMD_DISCARD    = 5'd1;
    localparam t_cmd CMD_ADD        = 5'd2;
    localparam t_cmd CMD_SUB        = 5'd3;
    localparam t_cmd CMD_MUL        = 5'd4;
    localparam t_cmd CMD_DIV        = 5'd5;
    localparam t_cmd CMD_LT         = 5'd6;
    localparam t_cmd CMD_LE         = 5'd7;
    localparam t_cmd CMD_EQ         = 5'd8;
    localparam t_cmd CMD_NE         = 5'd9;
    localparam t_cmd CMD_GT         = 5'd10;
    localparam t_cmd CMD_GE         = 5'd11;
    localparam t_cmd CMD_LAND       = 5'd12;
    localparam t_cmd CMD_LOR        = 5'd13;
    localparam t_cmd CMD_LXOR       = 5'd14;
    localparam t_cmd CMD_LNOT       = 5'd15;
    localparam t_cmd CMD_BAND       = 5'd16;
    localparam t_cmd CMD_BOR        = 5'd17;
    localparam t_cmd CMD_BXOR       = 5'd18;
    localparam t_cmd CMD_BNOT       = 5'd19;
    localparam t_cmd CMD_PUSH_LOCAL = 5'd20;
    localparam t_cmd CMD_POP_LOCAL  = 5'd21;
    localparam t_cmd CMD_JUMP       = 5'd22;
    localparam t_cmd CMD_JUMP_ZERO  = 5'd23;

    localparam t_fault FLT_NONE      = 3'd0;
    localparam t_fault FLT_POP_EMPTY = 3'd1;
    localparam t_fault FLT_PUSH_FULL = 3'd2;
    localparam t_fault FLT_DIV_ZERO  = 3'd3;
    localparam t_fault FLT_BAD_LOCAL = 3'd4;

endpackage
`default_nettype wire

// ===== hw/rtl/stack_machine_alu_core.sv =====
// Stack machine ALU core: executes one fetched instruction per transfer.
// Depends on smac_pkg (command and fault codes).
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+---------------------------------------------
//  input   | i_in_valid   | o_in_stall   | i_command, i_operand
//  output  | o_out_valid  | i_out_stall  | o_top_value, o_stack_count, o_branch_taken,
//          |              |              | o_branch_target, o_fault
//
// Each instruction has an accept step, reading the stack memory (entry below
// the top) and the local memory, then an execute and write-back step.
// Divide with a nonzero divisor runs a radix-2 restoring loop (ST_DIVIDE),
// then commits (ST_COMMIT). The synchronous-read memory port is why operands
// are read at accept. Reset (synchronous, active low) empties the stack and
// zeroes locals through per-entry valid bits; no clearing pass. A stalled
// output holds the commit; input is stalled whenever an instruction is in work.
`default_nettype none
module stack_machine_alu_core #(
    parameter int STACK_DEPTH = 64,
    parameter int LOCAL_COUNT = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire  smac_pkg::t_cmd     i_command,
    input  wire  smac_pkg::t_word    i_operand,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output logic signed [31:0]       o_top_value,
    output logic [6:0]               o_stack_count,
    output logic                     o_branch_taken,
    output smac_pkg::t_word          o_branch_target,
    output smac_pkg::t_fault         o_fault
);
    import smac_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int PW  = $clog2(STACK_DEPTH + 1);
    localparam int LIW = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIVIDE, ST_COMMIT} t_state;

    t_state          r_state;
    t_cmd            r_cmd;
    t_word           r_opw;
    logic [PW-1:0]   r_sp;
    t_word           r_tos;

    // memories
    t_word           r_stack [STACK_DEPTH];
    t_word           r_srd;
    t_word           r_lmem [LOCAL_COUNT];
    logic [LOCAL_COUNT-1:0] r_lvalid;
    t_word           r_lrd;
    logic            r_lok;

    // divider
    t_word           r_rem;
    t_word           r_quo;
    t_word           r_dvs;
    logic            r_neg;
    logic [4:0]      r_dcnt;

    // output register
    logic            r_ovalid;
    t_word           r_otop;
    logic [PW-1:0]   r_ocnt;
    logic            r_otaken;
    t_word           r_otarget;
    t_fault          r_ofault;

    logic            accept;
    logic            out_free;
    logic [PW-1:0]   sp_m2;
    logic [LIW-1:0]  lidx;
    logic            idx_ok;
    t_word           a_val;
    t_word           b_val;
    t_word           alu_v;
    t_word           v;
    t_word           loc_val;
    logic            div_go;
    logic            commit;
    logic [32:0]     div_trial;
    logic [32:0]     div_sub;

    logic [PW-1:0]   n_sp;
    t_word           n_tos;
    logic            s_we;
    logic [PW-1:0]   s_wa;
    t_word           s_wd;
    logic            l_we;
    t_fault          n_fault;
    logic            n_taken;
    logic [PW+6:0]   cnt_ext;

    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign out_free = !r_ovalid || !i_out_stall;
    assign sp_m2    = r_sp - PW'(2);
    assign lidx     = (r_state == ST_IDLE) ? i_operand[LIW-1:0] : r_opw[LIW-1:0];
    assign idx_ok   = r_opw < 32'(LOCAL_COUNT);

    assign b_val   = (r_sp != '0) ? r_tos : '0;
    assign a_val   = (r_sp >= PW'(2)) ? r_srd : '0;
    assign loc_val = r_lok ? r_lrd : '0;
    assign div_go  = (r_cmd == CMD_DIV) && (b_val != '0);

    always_comb begin
        case (r_cmd)
            CMD_ADD:  alu_v = a_val + b_val;
            CMD_SUB:  alu_v = a_val - b_val;
            CMD_MUL:  alu_v = a_val * b_val;
            CMD_LT:   alu_v = 32'($signed(a_val) <  $signed(b_val));
            CMD_LE:   alu_v = 32'($signed(a_val) <= $signed(b_val));
            CMD_EQ:   alu_v = 32'(a_val == b_val);
            CMD_NE:   alu_v = 32'(a_val != b_val);
            CMD_GT:   alu_v = 32'($signed(a_val) >  $signed(b_val));
            CMD_GE:   alu_v = 32'($signed(a_val) >= $signed(b_val));
            CMD_LAND: alu_v = 32'((a_val != '0) && (b_val != '0));
            CMD_LOR:  alu_v = 32'((a_val != '0) || (b_val != '0));
            CMD_LXOR: alu_v = 32'((a_val == '0) != (b_val == '0));
            CMD_LNOT: alu_v = 32'(b_val == '0);
            CMD_BAND: alu_v = a_val & b_val;
            CMD_BOR:  alu_v = a_val | b_val;
            CMD_BXOR: alu_v = a_val ^ b_val;
            CMD_BNOT: alu_v = ~b_val;
            default:  alu_v = '0;
        endcase
    end

    // divide result is taken in ST_COMMIT; a zero divisor pushes zero
    assign v = (r_state == ST_COMMIT) ? (r_neg ? (32'd0 - r_quo) : r_quo) : alu_v;

    assign commit = out_free &&
                    (((r_state == ST_EXEC) && !div_go) || (r_state == ST_COMMIT));

    // write-back decode: stack pointer, top cache, memory writes, fault
    always_comb begin
        n_sp    = r_sp;
        n_tos   = r_tos;
        s_we    = 1'b0;
        s_wa    = r_sp;
        s_wd    = v;
        l_we    = 1'b0;
        n_fault = FLT_NONE;
        n_taken = 1'b0;
        unique case (r_cmd) inside
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_LT, CMD_LE, CMD_EQ, CMD_NE,
            CMD_GT, CMD_GE, CMD_LAND, CMD_LOR, CMD_LXOR, CMD_BAND, CMD_BOR,
            CMD_BXOR: begin
                if (r_sp < PW'(2)) begin
                    n_fault = FLT_POP_EMPTY;
                    s_wa    = '0;
                end else begin
                    s_wa    = sp_m2;
                end
                if ((r_cmd == CMD_DIV) && (b_val == '0) && (n_fault == FLT_NONE)) begin
                    n_fault = FLT_DIV_ZERO;
                end
                s_we  = 1'b1;
                n_sp  = s_wa + PW'(1);
                n_tos = v;
            end
            CMD_LNOT, CMD_BNOT: begin
                if (r_sp == '0) begin
                    n_fault = FLT_POP_EMPTY;
                    s_wa    = '0;
                end else begin
                    s_wa    = r_sp - PW'(1);
                end
                s_we  = 1'b1;
                n_sp  = s_wa + PW'(1);
                n_tos = v;
            end
            CMD_PUSH_CONST, CMD_PUSH_LOCAL: begin
                s_wd = (r_cmd == CMD_PUSH_CONST) ? r_opw : loc_val;
                if ((r_cmd == CMD_PUSH_LOCAL) && !idx_ok) begin
                    n_fault = FLT_BAD_LOCAL;
                end else if (r_sp >= PW'(STACK_DEPTH)) begin
                    n_fault = FLT_PUSH_FULL;
                end else begin
                    s_we  = 1'b1;
                    n_sp  = r_sp + PW'(1);
                    n_tos = s_wd;
                end
            end
            CMD_DISCARD, CMD_POP_LOCAL, CMD_JUMP_ZERO: begin
                if (r_sp == '0) begin
                    n_fault = FLT_POP_EMPTY;
                end else begin
                    n_sp  = r_sp - PW'(1);
                    n_tos = a_val;
                end
                if (r_cmd == CMD_POP_LOCAL) begin
                    if (idx_ok) begin
                        l_we = 1'b1;
                    end else if (n_fault == FLT_NONE) begin
                        n_fault = FLT_BAD_LOCAL;
                    end
                end
                n_taken = (r_cmd == CMD_JUMP_ZERO) && (b_val == '0);
            end
            CMD_JUMP: begin
                n_taken = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // stack memory: read entry below top on accept, write on commit
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_srd <= r_stack[sp_m2[AW-1:0]];
        end
        if (commit && s_we) begin
            r_stack[s_wa[AW-1:0]] <= s_wd;
        end
    end

    // local memory: zero until written, tracked by valid bits
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lrd <= r_lmem[lidx];
        end
        if (commit && l_we) begin
            r_lmem[lidx] <= b_val;
        end
    end

    assign div_trial = {r_rem, r_quo[31]};
    assign div_sub   = div_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sp     <= '0;
            r_tos    <= '0;
            r_lvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_command;
                        r_opw   <= i_operand;
                        r_lok   <= r_lvalid[lidx];
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (div_go) begin
                        r_rem   <= '0;
                        r_quo   <= a_val[31] ? (32'd0 - a_val) : a_val;
                        r_dvs   <= b_val[31] ? (32'd0 - b_val) : b_val;
                        r_neg   <= a_val[31] ^ b_val[31];
                        r_dcnt  <= '0;
                        r_state <= ST_DIVIDE;
                    end else if (commit) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIVIDE: begin
                    // one quotient bit per cycle, dividend shifts out of r_quo
                    if (!div_sub[32]) begin
                        r_rem <= div_sub[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= div_trial[31:0];
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (commit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (commit) begin
                r_sp      <= n_sp;
                r_tos     <= n_tos;
                if (l_we) begin
                    r_lvalid[lidx] <= 1'b1;
                end
                r_ovalid  <= 1'b1;
                r_otop    <= (n_sp != '0) ? n_tos : '0;
                r_ocnt    <= n_sp;
                r_otaken  <= n_taken;
                r_otarget <= n_taken ? r_opw : '0;
                r_ofault  <= n_fault;
            end else if (!i_out_stall) begin
                r_ovalid  <= 1'b0;
            end
        end
    end

    assign cnt_ext         = {7'd0, r_ocnt};
    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_top_value     = $signed(r_otop);
    assign o_stack_count   = cnt_ext[6:0];
    assign o_branch_taken  = r_otaken;
    assign o_branch_target = r_otarget;
    assign o_fault         = r_ofault;

endmodule
`default_nettype wire
